// File: rtl/rcb_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rcb_pkg
// Shared widths, register map and configuration type of the replicated
// counter broadcast unit.
// ---------------------------------------------------------------------------
package rcb_pkg;

    localparam int MAX_NODES = 16;

    localparam int NCNT_W  = 5;
    localparam int BIDX_W  = 4;
    localparam int ADDR_W  = 48;
    localparam int LEN_W   = 32;
    localparam int OPS_W   = 32;
    localparam int OP_W    = 32;
    localparam int QPN_W   = 24;
    localparam int TOTAL_W = 64;
    localparam int HALF_W  = 32;
    localparam int J_W     = NCNT_W + 1;

    localparam int APB_AW  = 6;
    localparam int APB_DW  = 64;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_NODE_COUNT    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BOARD_INDEX   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LOCAL_ADDRESS = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_REMOTE_BASE   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WRITE_LENGTH  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_OP_LIMIT      = 3'd5;

    localparam logic [NCNT_W-1:0] NODE_COUNT_RST = 5'd1;

    typedef struct packed {
        logic [NCNT_W-1:0] node_count;
        logic [BIDX_W-1:0] board_index;
        logic [ADDR_W-1:0] local_address;
        logic [ADDR_W-1:0] remote_base;
        logic [LEN_W-1:0]  write_length;
        logic [OPS_W-1:0]  op_limit;
    } t_cfg;

    function automatic logic [NCNT_W-1:0] sat_nodes(input logic [NCNT_W-1:0] node_count);
        if (int'(node_count) > MAX_NODES) begin
            return NCNT_W'(MAX_NODES);
        end
        return node_count;
    endfunction

endpackage
`default_nettype wire

// File: rtl/replicated_counter_broadcast_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// replicated_counter_broadcast_unit
// Replicated 64-bit counter that broadcasts one remote-write descriptor per
// peer node for every update request.
// ---------------------------------------------------------------------------
// One request is taken at a time. An ignored request (operation limit
// reached) is dropped in the idle state, a query passes through the count
// step, and an update steps through the count, low, high and two remote
// address steps, then emits one descriptor per peer (nodes - 1, or nodes
// when the board index lies outside the group). The steps share a
// single 32-bit adder that bumps the operation count, adds the increment to
// the counter as two halves and forms the remote address as two halves;
// descriptors then go into the output register one per cycle while the
// receiver does not hold off. The next request is taken while the last
// descriptor still waits in the output register.
module replicated_counter_broadcast_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_op_valid,
    output logic                                    o_op_ready,
    input  wire logic signed [rcb_pkg::OP_W-1:0]    i_op_value,
    output logic                                    o_desc_valid,
    input  wire logic                               i_desc_ready,
    output logic             [rcb_pkg::QPN_W-1:0]   o_remote_qpn,
    output logic             [rcb_pkg::ADDR_W-1:0]  o_local_addr,
    output logic             [rcb_pkg::ADDR_W-1:0]  o_remote_addr,
    output logic             [rcb_pkg::LEN_W-1:0]   o_xfer_length,
    output logic signed      [rcb_pkg::HALF_W-1:0]  o_counter_value,
    output logic                                    o_last_write,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic        [rcb_pkg::APB_AW-1:0]  paddr,
    input  wire logic        [rcb_pkg::APB_DW-1:0]  pwdata,
    output logic             [rcb_pkg::APB_DW-1:0]  prdata,
    output logic                                    pready
);
    import rcb_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CNT  = 3'd1;
    localparam logic [2:0] S_LO   = 3'd2;
    localparam logic [2:0] S_HI   = 3'd3;
    localparam logic [2:0] S_RA0  = 3'd4;
    localparam logic [2:0] S_RA1  = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    t_cfg                   w_cfg;

    logic [2:0]             r_state;
    logic [2:0]             n_state;
    logic [OP_W-1:0]        r_op;
    logic [TOTAL_W-1:0]     r_total;
    logic [OPS_W-1:0]       r_ops;
    logic                   r_carry;
    logic [ADDR_W-1:0]      r_raddr;
    logic [QPN_W-1:0]       r_qpn;
    logic [J_W-1:0]         r_j;

    logic                   r_out_valid;
    logic [QPN_W-1:0]       r_out_qpn;
    logic [ADDR_W-1:0]      r_out_laddr;
    logic [ADDR_W-1:0]      r_out_raddr;
    logic [LEN_W-1:0]       r_out_len;
    logic [HALF_W-1:0]      r_out_cval;
    logic                   r_out_last;

    logic [HALF_W-1:0]      w_a;
    logic [HALF_W-1:0]      w_b;
    logic                   w_cin;
    logic [HALF_W:0]        w_sum;

    logic [NCNT_W-1:0]      w_n;
    logic [J_W-1:0]         w_n_ext;
    logic [J_W-1:0]         w_board_ext;
    logic [J_W-1:0]         w_first_j;
    logic [J_W-1:0]         w_j1;
    logic [J_W-1:0]         w_next_j;
    logic                   w_next_last;
    logic                   w_load;
    logic                   w_accept;
    logic                   w_limit_hit;
    logic [BIDX_W+NCNT_W-1:0] w_qpn_base;

    rcb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign o_op_ready  = (r_state == S_IDLE);
    assign w_accept    = i_op_valid && o_op_ready;
    assign w_limit_hit = (r_ops >= w_cfg.op_limit);

    // shared adder
    always_comb begin
        w_a   = '0;
        w_b   = '0;
        w_cin = 1'b0;
        case (r_state)
            S_CNT: begin
                w_a   = r_ops;
                w_cin = 1'b1;
            end
            S_LO: begin
                w_a = r_total[HALF_W-1:0];
                w_b = r_op;
            end
            S_HI: begin
                w_a   = r_total[TOTAL_W-1:HALF_W];
                w_b   = {HALF_W{r_op[OP_W-1]}};
                w_cin = r_carry;
            end
            S_RA0: begin
                w_a = w_cfg.remote_base[HALF_W-1:0];
                w_b = {{(HALF_W-BIDX_W-2){1'b0}}, w_cfg.board_index, 2'b00};
            end
            S_RA1: begin
                w_a   = HALF_W'(w_cfg.remote_base[ADDR_W-1:HALF_W]);
                w_cin = r_carry;
            end
            default: ;
        endcase
    end

    assign w_sum = {1'b0, w_a} + {1'b0, w_b} + {{HALF_W{1'b0}}, w_cin};

    assign w_n         = sat_nodes(w_cfg.node_count);
    assign w_n_ext     = J_W'(w_n);
    assign w_board_ext = J_W'(w_cfg.board_index);
    assign w_first_j   = (w_cfg.board_index == '0) ? J_W'(1) : '0;
    assign w_j1        = r_j + J_W'(1);
    assign w_next_j    = (w_j1 == w_board_ext) ? (w_j1 + J_W'(1)) : w_j1;
    assign w_next_last = (w_next_j >= w_n_ext);
    assign w_qpn_base  = (BIDX_W+NCNT_W)'(w_cfg.board_index)
                       * ((BIDX_W+NCNT_W)'(w_n) - (BIDX_W+NCNT_W)'(1));
    assign w_load      = (r_state == S_EMIT) && (!r_out_valid || i_desc_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && !w_limit_hit) begin
                    n_state = S_CNT;
                end
            end
            S_CNT:  n_state = (r_op == '0) ? S_IDLE : S_LO;
            S_LO:   n_state = S_HI;
            S_HI:   n_state = S_RA0;
            S_RA0:  n_state = S_RA1;
            S_RA1:  n_state = (w_first_j < w_n_ext) ? S_EMIT : S_IDLE;
            S_EMIT: begin
                if (w_load && w_next_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ops       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CNT) begin
                r_ops <= w_sum[OPS_W-1:0];
            end
            if (r_state == S_LO) begin
                r_total[HALF_W-1:0] <= w_sum[HALF_W-1:0];
            end
            if (r_state == S_HI) begin
                r_total[TOTAL_W-1:HALF_W] <= w_sum[HALF_W-1:0];
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_desc_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op <= i_op_value;
        end
        if (r_state == S_LO || r_state == S_RA0) begin
            r_carry <= w_sum[HALF_W];
        end
        if (r_state == S_RA0) begin
            r_raddr[HALF_W-1:0] <= w_sum[HALF_W-1:0];
        end
        if (r_state == S_RA1) begin
            r_raddr[ADDR_W-1:HALF_W] <= w_sum[ADDR_W-HALF_W-1:0];
            r_qpn                    <= QPN_W'(w_qpn_base);
            r_j                      <= w_first_j;
        end
        if (w_load) begin
            r_j         <= w_next_j;
            r_qpn       <= r_qpn + QPN_W'(1);
            r_out_qpn   <= r_qpn;
            r_out_laddr <= w_cfg.local_address;
            r_out_raddr <= r_raddr;
            r_out_len   <= w_cfg.write_length;
            r_out_cval  <= r_total[HALF_W-1:0];
            r_out_last  <= w_next_last;
        end
    end

    assign o_desc_valid    = r_out_valid;
    assign o_remote_qpn    = r_out_qpn;
    assign o_local_addr    = r_out_laddr;
    assign o_remote_addr   = r_out_raddr;
    assign o_xfer_length   = r_out_len;
    assign o_counter_value = r_out_cval;
    assign o_last_write    = r_out_last;

    a_emit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> ((r_j < w_n_ext) && (r_j != w_board_ext)))
        else $error("descriptor index out of group or on own board");

    a_limit_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_limit_hit) |=> (r_state == S_IDLE))
        else $error("request past operation limit was not dropped");

    a_query_no_desc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CNT && r_op == '0) |=> !w_load)
        else $error("query produced a descriptor");

endmodule
`default_nettype wire

// File: rtl/rcb_regs.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rcb_regs
// APB configuration registers of the replicated counter broadcast unit.
// ---------------------------------------------------------------------------
module rcb_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [rcb_pkg::APB_AW-1:0]  paddr,
    input  wire logic [rcb_pkg::APB_DW-1:0]  pwdata,
    output logic      [rcb_pkg::APB_DW-1:0]  prdata,
    output logic                             pready,
    output rcb_pkg::t_cfg                    o_cfg
);
    import rcb_pkg::*;

    t_cfg                   r_cfg;
    logic [REG_IDX_W-1:0]   w_idx;
    logic                   w_wr;

    assign w_idx  = paddr[APB_AW-1:APB_AW-REG_IDX_W];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.node_count    <= NODE_COUNT_RST;
            r_cfg.board_index   <= '0;
            r_cfg.local_address <= '0;
            r_cfg.remote_base   <= '0;
            r_cfg.write_length  <= '0;
            r_cfg.op_limit      <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_NODE_COUNT:    r_cfg.node_count    <= pwdata[NCNT_W-1:0];
                REG_BOARD_INDEX:   r_cfg.board_index   <= pwdata[BIDX_W-1:0];
                REG_LOCAL_ADDRESS: r_cfg.local_address <= pwdata[ADDR_W-1:0];
                REG_REMOTE_BASE:   r_cfg.remote_base   <= pwdata[ADDR_W-1:0];
                REG_WRITE_LENGTH:  r_cfg.write_length  <= pwdata[LEN_W-1:0];
                REG_OP_LIMIT:      r_cfg.op_limit      <= pwdata[OPS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_NODE_COUNT:    prdata = APB_DW'(r_cfg.node_count);
            REG_BOARD_INDEX:   prdata = APB_DW'(r_cfg.board_index);
            REG_LOCAL_ADDRESS: prdata = APB_DW'(r_cfg.local_address);
            REG_REMOTE_BASE:   prdata = APB_DW'(r_cfg.remote_base);
            REG_WRITE_LENGTH:  prdata = APB_DW'(r_cfg.write_length);
            REG_OP_LIMIT:      prdata = APB_DW'(r_cfg.op_limit);
            default:           prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// File: dv/rcb_descriptor_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rcb_descriptor_checker
// Watches the request, descriptor and register ports of the replicated
// counter broadcast unit, predicts the descriptors for every accepted
// request and compares each accepted descriptor field by field.
// ---------------------------------------------------------------------------
module rcb_descriptor_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_op_valid,
    input  wire logic                               i_op_ready,
    input  wire logic        [rcb_pkg::OP_W-1:0]    i_op_value,
    input  wire logic                               i_desc_valid,
    input  wire logic                               i_desc_ready,
    input  wire logic        [rcb_pkg::QPN_W-1:0]   i_remote_qpn,
    input  wire logic        [rcb_pkg::ADDR_W-1:0]  i_local_addr,
    input  wire logic        [rcb_pkg::ADDR_W-1:0]  i_remote_addr,
    input  wire logic        [rcb_pkg::LEN_W-1:0]   i_xfer_length,
    input  wire logic        [rcb_pkg::HALF_W-1:0]  i_counter_value,
    input  wire logic                               i_last_write,
    input  wire logic                               i_psel,
    input  wire logic                               i_penable,
    input  wire logic                               i_pwrite,
    input  wire logic        [rcb_pkg::APB_AW-1:0]  i_paddr,
    input  wire logic        [rcb_pkg::APB_DW-1:0]  i_pwdata,
    input  wire logic                               i_pready,
    output int                                      o_pending,
    output int                                      o_fail_count,
    output int                                      o_desc_count
);

    typedef struct packed {
        logic [rcb_pkg::QPN_W-1:0]  remote_qpn;
        logic [rcb_pkg::ADDR_W-1:0] local_addr;
        logic [rcb_pkg::ADDR_W-1:0] remote_addr;
        logic [rcb_pkg::LEN_W-1:0]  xfer_length;
        logic [rcb_pkg::HALF_W-1:0] counter_value;
        logic                       last_write;
    } t_desc;

    rcb_pkg::t_cfg                   cfg;
    logic [rcb_pkg::TOTAL_W-1:0]     running_total;
    logic [rcb_pkg::OPS_W-1:0]       ops_handled;
    t_desc                           pending_desc_q[$];
    int                              pending_total = 0;
    int                              fail_total = 0;
    int                              desc_total = 0;

    assign o_pending    = pending_total;
    assign o_fail_count = fail_total;
    assign o_desc_count = desc_total;

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_total++;
        end
    endfunction

    function automatic void broadcast_update(input logic [rcb_pkg::OP_W-1:0] op);
        int    nodes;
        int    board;
        int    last_j;
        t_desc d;
        logic [rcb_pkg::QPN_W-1:0]  qpn;
        logic [rcb_pkg::ADDR_W-1:0] raddr;
        if (ops_handled >= cfg.op_limit) begin
            return;
        end
        ops_handled = ops_handled + 1'b1;
        if (op == '0) begin
            return;
        end
        running_total = running_total + {{32{op[31]}}, op};
        nodes = (int'(cfg.node_count) > rcb_pkg::MAX_NODES) ? rcb_pkg::MAX_NODES
                                                             : int'(cfg.node_count);
        board = int'(cfg.board_index);
        qpn   = rcb_pkg::QPN_W'(board * (nodes - 1));
        raddr = cfg.remote_base + {42'd0, cfg.board_index, 2'b00};
        last_j = (board == nodes - 1) ? nodes - 2 : nodes - 1;
        for (int j = 0; j < nodes; j++) begin
            if (j != board) begin
                d.remote_qpn    = qpn;
                d.local_addr    = cfg.local_address;
                d.remote_addr   = raddr;
                d.xfer_length   = cfg.write_length;
                d.counter_value = running_total[rcb_pkg::HALF_W-1:0];
                d.last_write    = (j == last_j);
                pending_desc_q.push_back(d);
                qpn = qpn + 1'b1;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_desc got;
        t_desc want;
        if (!i_rst_n) begin
            cfg            = '0;
            cfg.node_count = rcb_pkg::NODE_COUNT_RST;
            running_total  = '0;
            ops_handled    = '0;
            pending_desc_q.delete();
        end else begin
            if (i_desc_valid && i_desc_ready) begin
                got.remote_qpn    = i_remote_qpn;
                got.local_addr    = i_local_addr;
                got.remote_addr   = i_remote_addr;
                got.xfer_length   = i_xfer_length;
                got.counter_value = i_counter_value;
                got.last_write    = i_last_write;
                desc_total++;
                if (pending_desc_q.size() == 0) begin
                    $error("descriptor with no pending request: qpn %0h, counter %0h",
                           got.remote_qpn, got.counter_value);
                    fail_total++;
                end else begin
                    want = pending_desc_q.pop_front();
                    check_field("remote_qpn", 64'(want.remote_qpn), 64'(got.remote_qpn));
                    check_field("local_addr", 64'(want.local_addr), 64'(got.local_addr));
                    check_field("remote_addr", 64'(want.remote_addr), 64'(got.remote_addr));
                    check_field("xfer_length", 64'(want.xfer_length), 64'(got.xfer_length));
                    check_field("counter_value", 64'(want.counter_value),
                                64'(got.counter_value));
                    check_field("last_write", 64'(want.last_write), 64'(got.last_write));
                end
            end
            if (i_op_valid && i_op_ready) begin
                broadcast_update(i_op_value);
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[rcb_pkg::APB_AW-1:3])
                    rcb_pkg::REG_NODE_COUNT: begin
                        cfg.node_count = i_pwdata[rcb_pkg::NCNT_W-1:0];
                    end
                    rcb_pkg::REG_BOARD_INDEX: begin
                        cfg.board_index = i_pwdata[rcb_pkg::BIDX_W-1:0];
                    end
                    rcb_pkg::REG_LOCAL_ADDRESS: begin
                        cfg.local_address = i_pwdata[rcb_pkg::ADDR_W-1:0];
                    end
                    rcb_pkg::REG_REMOTE_BASE: begin
                        cfg.remote_base = i_pwdata[rcb_pkg::ADDR_W-1:0];
                    end
                    rcb_pkg::REG_WRITE_LENGTH: begin
                        cfg.write_length = i_pwdata[rcb_pkg::LEN_W-1:0];
                    end
                    rcb_pkg::REG_OP_LIMIT: begin
                        cfg.op_limit = i_pwdata[rcb_pkg::OPS_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        pending_total = pending_desc_q.size();
    end

endmodule

// File: dv/tb_replicated_counter_broadcast_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_replicated_counter_broadcast_unit
// Drives counter requests and register writes into the broadcast unit with
// random idling and back-pressure; a separate checker predicts and compares
// every descriptor.
// ---------------------------------------------------------------------------
module tb_replicated_counter_broadcast_unit;

    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 32;
    localparam int ITEMS_PER_PHASE = 80;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               i_op_valid;
    logic                               o_op_ready;
    logic signed [rcb_pkg::OP_W-1:0]    i_op_value;
    logic                               o_desc_valid;
    logic                               i_desc_ready;
    logic        [rcb_pkg::QPN_W-1:0]   o_remote_qpn;
    logic        [rcb_pkg::ADDR_W-1:0]  o_local_addr;
    logic        [rcb_pkg::ADDR_W-1:0]  o_remote_addr;
    logic        [rcb_pkg::LEN_W-1:0]   o_xfer_length;
    logic signed [rcb_pkg::HALF_W-1:0]  o_counter_value;
    logic                               o_last_write;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic        [rcb_pkg::APB_AW-1:0]  paddr;
    logic        [rcb_pkg::APB_DW-1:0]  pwdata;
    logic        [rcb_pkg::APB_DW-1:0]  prdata;
    logic                               pready;

    int          pending;
    int          fail_count;
    int          desc_count;
    logic        quiet;
    logic        rx_hold_req;
    logic [31:0] limit_mirror;
    logic [31:0] handled;
    int          items_sent;
    int          settings_cnt;

    always #2 i_clk = ~i_clk;

    replicated_counter_broadcast_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op_valid     (i_op_valid),
        .o_op_ready     (o_op_ready),
        .i_op_value     (i_op_value),
        .o_desc_valid   (o_desc_valid),
        .i_desc_ready   (i_desc_ready),
        .o_remote_qpn   (o_remote_qpn),
        .o_local_addr   (o_local_addr),
        .o_remote_addr  (o_remote_addr),
        .o_xfer_length  (o_xfer_length),
        .o_counter_value(o_counter_value),
        .o_last_write   (o_last_write),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    rcb_descriptor_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op_valid     (i_op_valid),
        .i_op_ready     (o_op_ready),
        .i_op_value     (i_op_value),
        .i_desc_valid   (o_desc_valid),
        .i_desc_ready   (i_desc_ready),
        .i_remote_qpn   (o_remote_qpn),
        .i_local_addr   (o_local_addr),
        .i_remote_addr  (o_remote_addr),
        .i_xfer_length  (o_xfer_length),
        .i_counter_value(o_counter_value),
        .i_last_write   (o_last_write),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_pready       (pready),
        .o_pending      (pending),
        .o_fail_count   (fail_count),
        .o_desc_count   (desc_count)
    );

    initial begin
        i_desc_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_desc_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                i_desc_ready <= quiet || ($urandom_range(99) >= 8);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Drop the request valid, let the block drain, then wait out its latency.
    task automatic wait_idle();
        i_op_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [rcb_pkg::REG_IDX_W-1:0] idx,
                             input logic [rcb_pkg::APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == rcb_pkg::REG_OP_LIMIT) begin
            limit_mirror = data[31:0];
        end
    endtask

    task automatic program_group(input int nodes, input int board,
                                 input logic [47:0] laddr, input logic [47:0] rbase,
                                 input logic [31:0] len, input logic [31:0] limit);
        wait_idle();
        write_reg(rcb_pkg::REG_NODE_COUNT, 64'(nodes));
        write_reg(rcb_pkg::REG_BOARD_INDEX, 64'(board));
        write_reg(rcb_pkg::REG_LOCAL_ADDRESS, 64'(laddr));
        write_reg(rcb_pkg::REG_REMOTE_BASE, 64'(rbase));
        write_reg(rcb_pkg::REG_WRITE_LENGTH, 64'(len));
        write_reg(rcb_pkg::REG_OP_LIMIT, 64'(limit));
        settings_cnt++;
    endtask

    // Hold valid and payload until the request is taken.
    task automatic push_op(input logic [31:0] value);
        if (!quiet && $urandom_range(99) < 8) begin
            i_op_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_op_valid <= 1'b1;
        i_op_value <= value;
        do @(posedge i_clk); while (!o_op_ready);
        if (handled < limit_mirror) begin
            handled = handled + 1;
        end
        items_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] random_op();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10) begin
            return '0;
        end
        if (pick < 35) begin
            return $urandom_range(1) ? 32'($urandom_range(1, 16))
                                     : -32'($urandom_range(1, 16));
        end
        if (pick < 42) begin
            case ($urandom_range(3))
                0: return 32'h0000_0001;
                1: return 32'hFFFF_FFFF;
                2: return 32'h7FFF_FFFF;
                default: return 32'h8000_0000;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [47:0] random_addr();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return 48'({$urandom, $urandom});
        endcase
    endfunction

    initial begin
        int nodes;
        i_rst_n      = 1'b0;
        i_op_valid   = 1'b0;
        i_op_value   = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        quiet        = 1'b0;
        rx_hold_req  = 1'b0;
        limit_mirror = '0;
        handled      = '0;
        items_sent   = 0;
        settings_cnt = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // out of reset the operation limit is zero: requests are dropped
        push_op(32'd5);
        push_op(-32'sd3);

        program_group(4, 1, '1, 48'hFFFF_FFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_op(32'h0);
        push_op(32'h1);
        push_op(32'hFFFF_FFFF);
        push_op(32'h7FFF_FFFF);
        push_op(32'h8000_0000);
        push_op(32'h8000_0000);
        push_op(32'h5555_5555);
        push_op(32'hAAAA_AAAA);

        program_group(1, 0, '0, '0, '0, 32'hFFFF_FFFF);
        push_op(32'd9);
        program_group(0, 0, 48'h1234_5678_9ABC, 48'h0000_0000_0100, 32'd64, 32'hFFFF_FFFF);
        push_op(32'd3);
        program_group(20, 15, '1, '1, 32'd4096, 32'hFFFF_FFFF);
        push_op(32'd2);
        program_group(31, 0, '0, '1, '1, 32'hFFFF_FFFF);
        push_op(-32'sd7);
        program_group(5, 12, 48'h8000_0000_0000, '0, 32'd1, 32'hFFFF_FFFF);
        push_op(32'd11);
        program_group(16, 0, '0, '0, '0, 32'hFFFF_FFFF);
        push_op(32'h0001_0000);

        // limit lands inside a burst, then drops below the handled count
        program_group(3, 2, 48'hABCD, 48'h10, 32'd8, handled + 32'd2);
        push_op(32'd1);
        push_op(32'd2);
        push_op(32'd3);
        push_op(32'd4);
        wait_idle();
        write_reg(rcb_pkg::REG_OP_LIMIT, 64'd0);
        push_op(32'd6);

        for (int p = 0; p < 6; p++) begin
            if (p == 2) begin
                nodes = 16;
            end else if ($urandom_range(9) == 0) begin
                nodes = $urandom_range(31);
            end else begin
                nodes = $urandom_range(2, 16);
            end
            program_group(nodes, $urandom_range(15), random_addr(), random_addr(),
                          $urandom, 32'hFFFF_FFFF);
            quiet = (p == 0);
            if (p == 2) begin
                rx_hold_req = 1'b1;
            end
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (p == 3 && k == ITEMS_PER_PHASE / 2) begin
                    i_op_valid <= 1'b0;
                    while (pending != 0) @(negedge i_clk);
                end
                push_op(random_op());
            end
            quiet = 1'b0;
        end

        i_op_valid <= 1'b0;
        for (int k = 0; k < 20000 && pending != 0; k++) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Run sent %0d counter requests (%0d within the operation limit)",
                 items_sent, handled);
        $display("and checked %0d descriptors across %0d register settings",
                 desc_count, settings_cnt);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            if (pending != 0) begin
                $error("%0d expected descriptors never arrived", pending);
            end
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
